// ----- src/tors_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tors_pkg;

  // request opcodes
  localparam logic [2:0] OP_FRAME     = 3'd0;
  localparam logic [2:0] OP_WR_ORDER  = 3'd1;
  localparam logic [2:0] OP_WR_BREAK  = 3'd2;
  localparam logic [2:0] OP_WR_SPEED  = 3'd3;
  localparam logic [2:0] OP_JUMP      = 3'd4;
  localparam logic [2:0] OP_START     = 3'd5;
  localparam logic [2:0] OP_RESTART   = 3'd6;

  // register indexes (paddr[3:2])
  localparam int          CFG_AW               = 4;
  localparam logic [1:0]  REG_FRAMES_PER_TICK  = 2'd0;
  localparam logic [1:0]  REG_ORDER_COUNT      = 2'd1;
  localparam logic [1:0]  REG_PATTERN_COUNT    = 2'd2;

  localparam logic [15:0] FPT_RESET     = 16'd882;
  localparam logic [7:0]  TPR_RESET     = 8'd6;
  localparam logic [7:0]  END_MARK      = 8'hFF;
  localparam logic [7:0]  DEFAULT_BREAK = 8'd63;
  localparam logic [8:0]  NO_PATTERN    = 9'h1FF;

  typedef struct packed {
    logic [15:0] frames_per_tick;
    logic [7:0]  order_count;
    logic [7:0]  pattern_count;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/tors_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Generic RAM, one write port, one read port, registered read (old data on collision).
module tors_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/tors_tbl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Table port: RAM plus write forwarding, so the read data always reflects
// every write up to the cycle in which the address was presented.
module tors_tbl #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] ram_q;
  logic             hit_r;
  logic [WIDTH-1:0] fwd_r;

  tors_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= we && (waddr == raddr);
    end
    fwd_r <= wdata;
  end

  assign rdata = hit_r ? fwd_r : ram_q;

endmodule

`default_nettype wire

// ----- src/tors_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tors_cfg
  import tors_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_FRAMES_PER_TICK: cfg_nxt.frames_per_tick = pwdata[15:0];
        REG_ORDER_COUNT:     cfg_nxt.order_count     = pwdata[7:0];
        REG_PATTERN_COUNT:   cfg_nxt.pattern_count   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frames_per_tick <= FPT_RESET;
      cfg_r.order_count     <= 8'd0;
      cfg_r.pattern_count   <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAMES_PER_TICK: prdata = {16'd0, cfg_r.frames_per_tick};
      REG_ORDER_COUNT:     prdata = {24'd0, cfg_r.order_count};
      REG_PATTERN_COUNT:   prdata = {24'd0, cfg_r.pattern_count};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/tracker_order_row_sequencer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------------
// in_       | in        | in_valid / in_ready | op, table_index, table_value, jump_order/row
// out_      | out       | out_valid/out_ready | cur_order/pattern/row/tick, events, done, loops
// cfg (APB) | in        | psel/penable/pready | frames_per_tick, order_count, pattern_count
//
// One request per clock unless out_ready holds the output. A request passes the
// input register, then the result register. The order, break and speed tables
// sit in RAMs with registered reads addressed from the next-state position, so
// the data for the current position is ready when the next request arrives.
// Reset: synchronous, active low; the tables are not cleared (no sweep).
// Stalls: in_ready drops only when the input register is full and the result
// register is held by out_ready low.
module tracker_order_row_sequencer_core
  import tors_pkg::*;
#(
  parameter int ORDER_DEPTH   = 128,
  parameter int PATTERN_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [6:0]        in_table_index,
  input  logic [7:0]        in_table_value,
  input  logic [7:0]        in_jump_order,
  input  logic [7:0]        in_jump_row,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        out_cur_order,
  output logic [7:0]        out_cur_pattern,
  output logic [7:0]        out_cur_row,
  output logic [7:0]        out_cur_tick,
  output logic              out_tick_event,
  output logic              out_row_event,
  output logic              out_song_done,
  output logic [15:0]       out_loop_count,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int         OAW    = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
  localparam int         PAW    = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam logic [8:0] ODEPTH = 9'(ORDER_DEPTH);
  localparam logic [8:0] PDEPTH = 9'(PATTERN_DEPTH);

  cfg_t cfg;

  tors_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------
  // Input register and handshake
  // ---------------------------------------------------------------------
  logic       s1_valid_r;
  logic [2:0] s1_op_r;
  logic [6:0] s1_idx_r;
  logic [7:0] s1_val_r;
  logic [7:0] s1_jo_r;
  logic [7:0] s1_jr_r;
  logic       out_valid_r;
  logic       fire;
  logic       in_acc;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
    if (in_acc) begin
      s1_op_r  <= in_op;
      s1_idx_r <= in_table_index;
      s1_val_r <= in_table_value;
      s1_jo_r  <= in_jump_order;
      s1_jr_r  <= in_jump_row;
    end
  end

  // ---------------------------------------------------------------------
  // Song position state
  // ---------------------------------------------------------------------
  logic [15:0] fl_r,     fl_nxt;
  logic [7:0]  tick_r,   tick_nxt;
  logic [7:0]  tpr_r,    tpr_nxt;
  logic        tpr_load_r, tpr_load_nxt; // speed RAM holds ticks-per-row this cycle
  logic [7:0]  row_r,    row_nxt;
  logic [6:0]  order_r,  order_nxt;
  logic [7:0]  pat_r,    pat_nxt;
  logic [8:0]  last_r,   last_nxt;
  logic        done_r,   done_nxt;
  logic [15:0] loops_r,  loops_nxt;
  logic        jmp_r,    jmp_nxt;
  logic [7:0]  pord_r,   pord_nxt;
  logic [7:0]  prow_r,   prow_nxt;
  logic        started_r, started_nxt;
  logic [7:0]  order0_r, order0_nxt;     // shadow of order entry 0
  logic [7:0]  speed0_r, speed0_nxt;     // shadow of speed entry 0

  // table ports
  logic            ord_we, brk_we, spd_we;
  logic [OAW-1:0]  ord_waddr, ord_j_addr, ord_n_addr;
  logic [PAW-1:0]  pat_waddr, pat_raddr;
  logic [7:0]      ord_j_rd, ord_n_rd, brk_rd, spd_rd;
  logic [7:0]      ord_n_full;

  // combinational helpers
  logic [7:0] eff_tpr;
  logic [7:0] tick_inc;
  logic [7:0] brk;
  logic [7:0] next_ord;
  logic       jmp_ok;
  logic       end_hit;
  logic       tick_ev;
  logic       row_ev;

  function automatic logic known(input logic [7:0] p, input logic [7:0] cnt);
    return (p < cnt) && ({1'b0, p} < PDEPTH);
  endfunction

  always_comb begin
    fl_nxt       = fl_r;
    tick_nxt     = tick_r;
    eff_tpr      = tpr_load_r ? spd_rd : tpr_r;
    tpr_nxt      = eff_tpr;
    tpr_load_nxt = 1'b0;
    row_nxt      = row_r;
    order_nxt    = order_r;
    pat_nxt      = pat_r;
    last_nxt     = last_r;
    done_nxt     = done_r;
    loops_nxt    = loops_r;
    jmp_nxt      = jmp_r;
    pord_nxt     = pord_r;
    prow_nxt     = prow_r;
    started_nxt  = started_r;
    order0_nxt   = order0_r;
    speed0_nxt   = speed0_r;
    ord_we       = 1'b0;
    brk_we       = 1'b0;
    spd_we       = 1'b0;
    tick_ev      = 1'b0;
    row_ev       = 1'b0;

    tick_inc = tick_r + 8'd1;
    brk      = known(pat_r, cfg.pattern_count) ? brk_rd : DEFAULT_BREAK;
    next_ord = {1'b0, order_r} + 8'd1;
    jmp_ok   = (pord_r < cfg.order_count) && ({1'b0, pord_r} < ODEPTH);
    end_hit  = next_ord[7] || ({1'b0, next_ord} >= ODEPTH) || (ord_n_rd == END_MARK);

    if (fire) begin
      case (s1_op_r)
        OP_FRAME: begin
          if (fl_r <= 16'd1) begin
            fl_nxt   = cfg.frames_per_tick;
            tick_ev  = 1'b1;
            tick_nxt = tick_inc;
            if ((eff_tpr != 8'd0) && (tick_inc == eff_tpr)) begin
              // row boundary
              tick_nxt = 8'd0;
              if (started_r && !done_r) begin
                if (jmp_r) begin
                  jmp_nxt  = 1'b0;
                  pord_nxt = 8'd0;
                  prow_nxt = 8'd0;
                  if (jmp_ok) begin
                    order_nxt = pord_r[6:0];
                    pat_nxt   = ord_j_rd;
                    row_nxt   = prow_r;
                  end
                end else if (row_r < brk) begin
                  row_nxt = row_r + 8'd1;
                end else begin
                  row_nxt = 8'd0;
                  if (end_hit) begin
                    // song end: back to the top, frozen until restart
                    order_nxt = 7'd0;
                    pat_nxt   = order0_r;
                    loops_nxt = loops_r + 16'd1;
                    done_nxt  = 1'b1;
                  end else begin
                    order_nxt = next_ord[6:0];
                    pat_nxt   = ord_n_rd;
                  end
                end
              end
              // new known pattern reloads the speed; value is picked up next cycle
              if (known(pat_nxt, cfg.pattern_count) && ({1'b0, pat_nxt} != last_r)) begin
                tpr_load_nxt = 1'b1;
              end
              last_nxt = {1'b0, pat_nxt};
              row_ev   = started_r && !done_nxt;
            end
          end else begin
            fl_nxt = fl_r - 16'd1;
          end
        end
        OP_WR_ORDER: begin
          ord_we = ({2'b00, s1_idx_r} < ODEPTH);
          if (ord_we && (s1_idx_r == 7'd0)) begin
            order0_nxt = s1_val_r;
          end
        end
        OP_WR_BREAK: begin
          brk_we = ({2'b00, s1_idx_r} < PDEPTH);
        end
        OP_WR_SPEED: begin
          spd_we = ({2'b00, s1_idx_r} < PDEPTH);
          if (spd_we && (s1_idx_r == 7'd0)) begin
            speed0_nxt = s1_val_r;
          end
        end
        OP_JUMP: begin
          jmp_nxt  = 1'b1;
          pord_nxt = s1_jo_r;
          prow_nxt = s1_jr_r;
        end
        OP_START: begin
          done_nxt    = 1'b0;
          loops_nxt   = 16'd0;
          row_nxt     = 8'd0;
          jmp_nxt     = 1'b0;
          pord_nxt    = 8'd0;
          prow_nxt    = 8'd0;
          tick_nxt    = 8'd0;
          order_nxt   = 7'd0;
          fl_nxt      = cfg.frames_per_tick;
          pat_nxt     = order0_r;
          last_nxt    = {1'b0, order0_r};
          started_nxt = 1'b1;
          if (known(order0_r, cfg.pattern_count)) begin
            tpr_load_nxt = 1'b1;
          end else begin
            tpr_nxt = speed0_r;
          end
        end
        OP_RESTART: begin
          if (started_r && done_r) begin
            done_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Read addresses follow the next-state position.
  assign ord_n_full = {1'b0, order_nxt} + 8'd1;
  assign ord_n_addr = OAW'(ord_n_full);
  assign ord_j_addr = OAW'({1'b0, pord_nxt[6:0]});
  assign ord_waddr  = OAW'({1'b0, s1_idx_r});
  assign pat_waddr  = PAW'({1'b0, s1_idx_r});
  assign pat_raddr  = PAW'(pat_nxt);

  // Two order table copies: one follows the jump target, one the next entry.
  tors_tbl #(.WIDTH(8), .DEPTH(ORDER_DEPTH)) u_ord_jmp (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (s1_val_r),
    .raddr (ord_j_addr),
    .rdata (ord_j_rd)
  );

  tors_tbl #(.WIDTH(8), .DEPTH(ORDER_DEPTH)) u_ord_nxt (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (s1_val_r),
    .raddr (ord_n_addr),
    .rdata (ord_n_rd)
  );

  tors_tbl #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_brk (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (brk_we),
    .waddr (pat_waddr),
    .wdata (s1_val_r),
    .raddr (pat_raddr),
    .rdata (brk_rd)
  );

  tors_tbl #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_spd (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (spd_we),
    .waddr (pat_waddr),
    .wdata (s1_val_r),
    .raddr (pat_raddr),
    .rdata (spd_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_r       <= 16'd0;
      tick_r     <= 8'd0;
      tpr_r      <= TPR_RESET;
      tpr_load_r <= 1'b0;
      row_r      <= 8'd0;
      order_r    <= 7'd0;
      pat_r      <= 8'd0;
      last_r     <= NO_PATTERN;
      done_r     <= 1'b0;
      loops_r    <= 16'd0;
      jmp_r      <= 1'b0;
      pord_r     <= 8'd0;
      prow_r     <= 8'd0;
      started_r  <= 1'b0;
    end else begin
      fl_r       <= fl_nxt;
      tick_r     <= tick_nxt;
      tpr_r      <= tpr_nxt;
      tpr_load_r <= tpr_load_nxt;
      row_r      <= row_nxt;
      order_r    <= order_nxt;
      pat_r      <= pat_nxt;
      last_r     <= last_nxt;
      done_r     <= done_nxt;
      loops_r    <= loops_nxt;
      jmp_r      <= jmp_nxt;
      pord_r     <= pord_nxt;
      prow_r     <= prow_nxt;
      started_r  <= started_nxt;
    end
    // table shadows, undefined until written like the tables
    order0_r <= order0_nxt;
    speed0_r <= speed0_nxt;
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [6:0]  res_order_r;
  logic [7:0]  res_pat_r;
  logic [7:0]  res_row_r;
  logic [7:0]  res_tick_r;
  logic        res_tick_ev_r;
  logic        res_row_ev_r;
  logic        res_done_r;
  logic [15:0] res_loops_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      res_order_r   <= order_nxt;
      res_pat_r     <= pat_nxt;
      res_row_r     <= row_nxt;
      res_tick_r    <= tick_nxt;
      res_tick_ev_r <= tick_ev;
      res_row_ev_r  <= row_ev;
      res_done_r    <= done_nxt;
      res_loops_r   <= loops_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cur_order   = res_order_r;
  assign out_cur_pattern = res_pat_r;
  assign out_cur_row     = res_row_r;
  assign out_cur_tick    = res_tick_r;
  assign out_tick_event  = res_tick_ev_r;
  assign out_row_event   = res_row_ev_r;
  assign out_song_done   = res_done_r;
  assign out_loop_count  = res_loops_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_tpr_load_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    tpr_load_r |-> $past(fire))
    else $error("speed reload flagged without a processed request");

  a_done_counts_loop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> (loops_r == $past(loops_r) + 16'd1))
    else $error("song end without a loop count");

  a_done_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> started_r)
    else $error("song done before start");

  a_row_ev_has_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_row_ev_r) |-> res_tick_ev_r)
    else $error("row event without tick event");

endmodule

`default_nettype wire

// ----- tb/tb_tracker_order_row_sequencer_core.sv -----
`timescale 1ns / 1ps

module tb_tracker_order_row_sequencer_core;
  import tors_pkg::*;

  localparam logic [2:0] OP_NOP = 3'd7;   // not decoded by the block
  localparam int SLOTS = 128;             // order and pattern table depth
  localparam int CYCLE_LIMIT = 1000000;

  // one request as driven on the in_ channel
  typedef struct packed {
    logic [2:0] op;
    logic [6:0] table_index;
    logic [7:0] table_value;
    logic [7:0] jump_order;
    logic [7:0] jump_row;
  } req_t;

  // song position reported after each request
  typedef struct packed {
    logic [6:0]  order;
    logic [7:0]  pattern;
    logic [7:0]  row;
    logic [7:0]  tick;
    logic        tick_ev;
    logic        row_ev;
    logic        done;
    logic [15:0] loops;
  } song_pos_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_op = '0;
  logic [6:0]  in_table_index = '0;
  logic [7:0]  in_table_value = '0;
  logic [7:0]  in_jump_order = '0;
  logic [7:0]  in_jump_row = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [6:0]  out_cur_order;
  logic [7:0]  out_cur_pattern;
  logic [7:0]  out_cur_row;
  logic [7:0]  out_cur_tick;
  logic        out_tick_event;
  logic        out_row_event;
  logic        out_song_done;
  logic [15:0] out_loop_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tracker_order_row_sequencer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .in_jump_order   (in_jump_order),
    .in_jump_row     (in_jump_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cur_order   (out_cur_order),
    .out_cur_pattern (out_cur_pattern),
    .out_cur_row     (out_cur_row),
    .out_cur_tick    (out_cur_tick),
    .out_tick_event  (out_tick_event),
    .out_row_event   (out_row_event),
    .out_song_done   (out_song_done),
    .out_loop_count  (out_loop_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the sequencer, updated once per accepted request.
  // Tables start unknown; the run loads every entry before anything reads one.
  // ---------------------------------------------------------------------------
  logic [7:0]  order_list    [SLOTS];
  logic [7:0]  row_limit     [SLOTS];   // last row of each pattern
  logic [7:0]  pattern_speed [SLOTS];   // ticks per row of each pattern
  logic [15:0] cfg_fpt = FPT_RESET;
  logic [7:0]  cfg_orders = '0;
  logic [7:0]  cfg_patterns = '0;
  logic [15:0] frames_to_tick = '0;
  logic [7:0]  tick_in_row = '0;
  logic [7:0]  row_ticks = TPR_RESET;
  logic [7:0]  row_now = '0;
  logic [6:0]  order_now = '0;
  logic [7:0]  pattern_playing = '0;
  logic [8:0]  pattern_loaded = NO_PATTERN;  // pattern entered last, whether or not its speed was taken
  logic        at_end = 1'b0;
  logic [15:0] loop_ctr = '0;
  logic        jump_armed = 1'b0;
  logic [7:0]  jump_to_order = '0;
  logic [7:0]  jump_to_row = '0;
  logic        playing = 1'b0;

  song_pos_t song_pos_q[$];   // positions still owed by the block
  song_pos_t want, seen;
  int mismatches = 0;
  int cycle_cnt = 0;

  // stall control: a calm stretch means no idling on that side
  int  src_left = 0, sink_left = 0, sink_hold = 0;
  bit  src_calm = 1'b0, sink_calm = 1'b0;

  function automatic bit pattern_has_entries(logic [7:0] p);
    return p < cfg_patterns && p < SLOTS;
  endfunction

  // speed comes from the table only when a known pattern is entered anew
  function automatic void reload_row_ticks();
    if (pattern_has_entries(pattern_playing) && {1'b0, pattern_playing} != pattern_loaded)
      row_ticks = pattern_speed[pattern_playing[6:0]];
    pattern_loaded = {1'b0, pattern_playing};
  endfunction

  function automatic song_pos_t song_step(req_t r);
    song_pos_t p;
    logic tick_ev, row_ev;
    int brk, nxt;
    tick_ev = 1'b0;
    row_ev = 1'b0;
    case (r.op)
      OP_FRAME: begin
        if (frames_to_tick <= 16'd1) begin
          frames_to_tick = cfg_fpt;
          tick_ev = 1'b1;
          tick_in_row = tick_in_row + 8'd1;
          if (row_ticks != 8'd0 && tick_in_row == row_ticks) begin
            tick_in_row = '0;
            // position moves only while playing and not parked at song end
            if (playing && !at_end) begin
              if (jump_armed) begin
                jump_armed = 1'b0;
                if (jump_to_order < cfg_orders && jump_to_order < SLOTS) begin
                  order_now = jump_to_order[6:0];
                  pattern_playing = order_list[order_now];
                  row_now = jump_to_row;
                end
                jump_to_order = '0;
                jump_to_row = '0;
              end else begin
                brk = pattern_has_entries(pattern_playing) ?
                      int'(row_limit[pattern_playing[6:0]]) : int'(DEFAULT_BREAK);
                if (int'(row_now) < brk) begin
                  row_now = row_now + 8'd1;
                end else begin
                  row_now = '0;
                  nxt = int'(order_now) + 1;
                  if (nxt >= SLOTS || order_list[nxt] == END_MARK) begin
                    // song end: back to the top, frozen until restart
                    order_now = '0;
                    pattern_playing = order_list[0];
                    loop_ctr = loop_ctr + 16'd1;
                    at_end = 1'b1;
                  end else begin
                    order_now = nxt[6:0];
                    pattern_playing = order_list[nxt];
                  end
                end
              end
            end
            reload_row_ticks();
            row_ev = playing && !at_end;
          end
        end else begin
          frames_to_tick = frames_to_tick - 16'd1;
        end
      end
      OP_WR_ORDER: order_list[r.table_index] = r.table_value;
      OP_WR_BREAK: row_limit[r.table_index] = r.table_value;
      OP_WR_SPEED: pattern_speed[r.table_index] = r.table_value;
      OP_JUMP: begin
        jump_armed = 1'b1;
        jump_to_order = r.jump_order;
        jump_to_row = r.jump_row;
      end
      OP_START: begin
        at_end = 1'b0;
        loop_ctr = '0;
        pattern_loaded = NO_PATTERN;
        row_now = '0;
        jump_armed = 1'b0;
        jump_to_order = '0;
        jump_to_row = '0;
        tick_in_row = '0;
        order_now = '0;
        row_ticks = pattern_speed[0];
        frames_to_tick = cfg_fpt;
        pattern_playing = order_list[0];
        reload_row_ticks();
        playing = 1'b1;
      end
      OP_RESTART: begin
        if (playing && at_end) at_end = 1'b0;
      end
      default: ;
    endcase
    p.order = order_now;
    p.pattern = pattern_playing;
    p.row = row_now;
    p.tick = tick_in_row;
    p.tick_ev = tick_ev;
    p.row_ev = row_ev;
    p.done = at_end;
    p.loops = loop_ctr;
    return p;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic string pos_text(song_pos_t p);
    return $sformatf("order %0d pattern %0d row %0d tick %0d tev %0b rev %0b done %0b loops %0d",
                     p.order, p.pattern, p.row, p.tick, p.tick_ev, p.row_ev, p.done,
                     p.loops);
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int pick_idle();
    int w;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // table contents shaped so songs run several orders deep before the end mark
  function automatic logic [7:0] table_content(logic [2:0] op);
    int w;
    w = $urandom_range(0, 99);
    case (op)
      OP_WR_ORDER: begin
        if (w < 6) return END_MARK;
        if (w < 14) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 15));
      end
      OP_WR_BREAK: begin
        if (w < 5) return 8'hFF;   // row 255 is the pattern's last row
        if (w < 10) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 7));
      end
      OP_WR_SPEED: begin
        if (w < 6) return 8'd0;    // rows stall, ticks keep running
        if (w < 9) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, 3));
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic req_t rand_req(logic [2:0] op);
    req_t r;
    r.op = op;
    r.table_index = 7'($urandom_range(0, 127));
    r.table_value = 8'($urandom_range(0, 255));
    r.jump_order = 8'($urandom_range(0, 255));
    r.jump_row = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int w;
    w = $urandom_range(0, 99);
    r = rand_req(w < 72 ? OP_FRAME : w < 79 ? OP_JUMP : w < 85 ? OP_RESTART :
                 w < 89 ? OP_WR_ORDER : w < 92 ? OP_WR_BREAK : w < 95 ? OP_WR_SPEED :
                 w < 97 ? OP_START : OP_NOP);
    if ((r.op == OP_WR_ORDER || r.op == OP_WR_BREAK || r.op == OP_WR_SPEED) &&
        $urandom_range(0, 9) < 8)
      r.table_value = table_content(r.op);
    if (r.op == OP_JUMP) begin
      if ($urandom_range(0, 9) < 7) r.jump_row = 8'($urandom_range(0, 7));
      if (cfg_orders != 8'd0 && $urandom_range(0, 9) < 7)
        r.jump_order = 8'($urandom_range(0, int'(cfg_orders) - 1));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: payload changes at the falling edge, acceptance is seen at
  // the rising edge, and the predicted position is queued right there.
  // ---------------------------------------------------------------------------
  task automatic send_req(input req_t r);
    int gap;
    if (src_left == 0) begin
      src_calm = ($urandom_range(0, 3) == 0);
      src_left = $urandom_range(20, 150);
    end
    src_left--;
    gap = src_calm ? 0 : pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= r.op;
    in_table_index <= r.table_index;
    in_table_value <= r.table_value;
    in_jump_order <= r.jump_order;
    in_jump_row <= r.jump_row;
    do @(posedge clk); while (!in_ready);
    song_pos_q.push_back(song_step(r));
  endtask

  // a = table index or jump order, b = table value or jump row
  task automatic send_ctl(input logic [2:0] op, input int a, input int b);
    req_t r;
    r = rand_req(op);
    if (op == OP_JUMP) begin
      r.jump_order = 8'(a);
      r.jump_row = 8'(b);
    end else begin
      r.table_index = 7'(a);
      r.table_value = 8'(b);
    end
    send_req(r);
  endtask

  task automatic send_frames(input int n);
    repeat (n) send_req(rand_req(OP_FRAME));
  endtask

  // stop sending and hold off until every owed position has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (song_pos_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic [1:0] idx);
    logic [31:0] exp_val;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAMES_PER_TICK: exp_val = {16'h0, cfg_fpt};
      REG_ORDER_COUNT:     exp_val = {24'h0, cfg_orders};
      default:             exp_val = {24'h0, cfg_patterns};
    endcase
    if (prdata !== exp_val)
      flag_mismatch($sformatf("register %0d read: expected %0d got %0d", idx, exp_val,
                              prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // only called with the block idle; the write is read back right away
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAMES_PER_TICK: cfg_fpt = val;
      REG_ORDER_COUNT:     cfg_orders = val[7:0];
      default:             cfg_patterns = val[7:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_read_check(idx);
  endtask

  // new settings, a start request, then a stretch of random traffic
  task automatic play_phase(input logic [15:0] fpt, input logic [7:0] orders,
                            input logic [7:0] patterns, input int n);
    wait_drained();
    cfg_write(REG_FRAMES_PER_TICK, fpt);
    cfg_write(REG_ORDER_COUNT, {8'h0, orders});
    cfg_write(REG_PATTERN_COUNT, {8'h0, patterns});
    send_req(rand_req(OP_START));
    repeat (n) begin
      if ($urandom_range(0, 99) == 0) wait_drained();
      send_req(random_req());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and a check of every accepted position
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_calm = ($urandom_range(0, 3) == 0);
      sink_left = $urandom_range(50, 300);
    end else begin
      sink_left--;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else if (!sink_calm) begin
      sink_hold = pick_idle();
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.order = out_cur_order;
      seen.pattern = out_cur_pattern;
      seen.row = out_cur_row;
      seen.tick = out_cur_tick;
      seen.tick_ev = out_tick_event;
      seen.row_ev = out_row_event;
      seen.done = out_song_done;
      seen.loops = out_loop_count;
      if (song_pos_q.size() == 0) begin
        flag_mismatch({"result with no request outstanding: ", pos_text(seen)});
      end else begin
        want = song_pos_q.pop_front();
        if (seen.order !== want.order || seen.pattern !== want.pattern ||
            seen.row !== want.row || seen.tick !== want.tick ||
            seen.tick_ev !== want.tick_ev || seen.row_ev !== want.row_ev ||
            seen.done !== want.done || seen.loops !== want.loops)
          flag_mismatch({"expected ", pos_text(want), " got ", pos_text(seen)});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    cfg_read_check(REG_FRAMES_PER_TICK);
    cfg_read_check(REG_ORDER_COUNT);
    cfg_read_check(REG_PATTERN_COUNT);
  endtask

  // before start: ticks and row boundaries run, position holds, jump waits
  task automatic test_before_start();
    cfg_write(REG_FRAMES_PER_TICK, 16'd1);
    send_ctl(OP_NOP, 0, 0);
    send_ctl(OP_RESTART, 0, 0);
    send_ctl(OP_JUMP, 3, 4);
    send_frames(14);
  endtask

  task automatic test_table_load();
    for (int i = 0; i < SLOTS; i++) begin
      send_ctl(OP_WR_ORDER, i, table_content(OP_WR_ORDER));
      send_ctl(OP_WR_BREAK, i, table_content(OP_WR_BREAK));
      send_ctl(OP_WR_SPEED, i, table_content(OP_WR_SPEED));
    end
  endtask

  // short known song: plays to the end mark, restarts, jumps to the last order
  // slot so the song ends past the table, then an out-of-range jump is dropped
  task automatic test_song_walk();
    wait_drained();
    cfg_write(REG_ORDER_COUNT, 16'd128);
    cfg_write(REG_PATTERN_COUNT, 16'd128);
    send_ctl(OP_WR_ORDER, 0, 0);
    send_ctl(OP_WR_ORDER, 1, 1);
    send_ctl(OP_WR_ORDER, 2, END_MARK);
    send_ctl(OP_WR_ORDER, 127, 1);
    send_ctl(OP_WR_BREAK, 0, 1);
    send_ctl(OP_WR_BREAK, 1, 0);
    send_ctl(OP_WR_SPEED, 0, 1);
    send_ctl(OP_WR_SPEED, 1, 2);
    send_ctl(OP_START, 0, 0);
    send_frames(6);
    send_ctl(OP_RESTART, 0, 0);
    send_ctl(OP_JUMP, 127, 3);
    send_frames(3);
    send_ctl(OP_RESTART, 0, 0);
    send_ctl(OP_JUMP, 255, 255);
    send_frames(2);
  endtask

  // register extremes: zero frames per tick, the widest count, no patterns
  task automatic test_config_extremes();
    play_phase(16'd0, 8'd0, 8'd0, 40);
    play_phase(16'hFFFF, 8'd128, 8'd128, 30);
    play_phase(16'd2, 8'd255, 8'd255, 40);
    play_phase(16'd1, 8'd128, 8'd0, 40);
  endtask

  task automatic test_random_play();
    int sent, n, w;
    logic [15:0] fpt;
    logic [7:0] orders, patterns;
    sent = 0;
    while (sent < 600) begin
      n = $urandom_range(100, 250);
      w = $urandom_range(0, 99);
      fpt = (w < 70) ? 16'($urandom_range(1, 3)) :
            (w < 85) ? 16'd0 : 16'($urandom_range(4, 20));
      orders = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(0, 128));
      patterns = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(0, 128));
      play_phase(fpt, orders, patterns, n);
      sent += n;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_before_start();
    test_table_load();
    test_song_walk();
    test_config_extremes();
    test_random_play();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && song_pos_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- tracker_order_row_sequencer_core.f -----
src/tors_pkg.sv
src/tors_ram.sv
src/tors_tbl.sv
src/tors_cfg.sv
src/tracker_order_row_sequencer_core.sv
tb/tb_tracker_order_row_sequencer_core.sv
